/* hdl/fdc_pkg.sv */
// Shared types and constants for the flood and drain cycle controller.
// No dependencies; imported by fdc_div, the core, the cycle checker and the testbench.
`timescale 1ns / 1ps

package fdc_pkg;

	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned DIVD_W  = 16;

	// Level thresholds used by the cycle rules
	localparam logic [LEVEL_W-1:0] FINAL_MAX_LEVEL = 8'h80;
	localparam logic [LEVEL_W-1:0] SIPHON_RISE     = 8'h18;
	localparam logic [LEVEL_W-1:0] DRAIN_MARGIN    = 8'h20;
	localparam logic [LEVEL_W-1:0] FULL_SCALE      = 8'hff;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_FLOOD = 3'd1,
		PH_FINAL = 3'd2,
		PH_DRAIN = 3'd3,
		PH_FAIL  = 3'd4
	} fdc_phase_t;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_POLL  = 1'b1
	} fdc_func_t;

	typedef enum logic [1:0] {
		CFG_PUMP_THROTTLE  = 2'd0,
		CFG_BOOST_THROTTLE = 2'd1,
		CFG_MIN_START_PCT  = 2'd2
	} fdc_cfg_idx_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_LOAD = 2'd1,
		SEQ_DIV  = 2'd2,
		SEQ_HOLD = 2'd3
	} fdc_seq_t;

	typedef struct packed {
		logic              func;
		logic [LEVEL_W-1:0] level;
	} fdc_in_t;

	typedef struct packed {
		logic [2:0]         phase;
		logic               low_water_error;
		logic [LEVEL_W-1:0] pump_drive;
		logic               keep_polling;
		logic [LEVEL_W-1:0] top_pot_level;
	} fdc_out_t;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic run;
		logic done;
	} fdc_div_stat_t;

endpackage

/* hdl/fdc_div.sv */
// Restoring divider, one quotient bit per cycle: 16-bit dividend, 8-bit divisor.
// Depends on fdc_pkg.
`timescale 1ns / 1ps

module fdc_div import fdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIVD_W-1:0]   dividend,
	input  logic [LEVEL_W-1:0]  divisor,
	output fdc_div_stat_t       stat,
	output logic [DIVD_W-1:0]   quotient
);

	localparam int unsigned CNT_W = $clog2(DIVD_W);

	logic [LEVEL_W-1:0] rem_q;
	logic [LEVEL_W-1:0] dsr_q;
	logic [DIVD_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	logic [LEVEL_W:0]   trial;
	logic               fits;
	logic [LEVEL_W:0]   trial_sub;

	assign trial     = {rem_q, quo_q[DIVD_W-1]};
	assign fits      = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (run_q) begin
			// remainder stays below divisor, so the top trial bit drops out
			rem_q <= fits ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign stat.run  = run_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* hdl/flood_drain_cycle_controller_core.sv */
// Flood and drain cycle controller core; uses fdc_pkg and fdc_div.
// Each item passes the load step, the bit-serial divide and, while out_stall holds, the hold step.
// A new item is taken only once the previous result is loaded; the top-pot divider sets the pace.
// in_stall is high from accept until the result is loaded into the output register.
// Reset (arst_n low): phase idle, all cycle state zero, registers 70/120/50; no clearing pass.
`timescale 1ns / 1ps

module flood_drain_cycle_controller_core import fdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fdc_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output fdc_out_t           out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [LEVEL_W-1:0] cfg_data
);

	// configuration
	logic [LEVEL_W-1:0] pump_thr_q;
	logic [LEVEL_W-1:0] boost_thr_q;
	logic [6:0]         min_pct_q;

	// cycle state
	fdc_phase_t         phase_q, phase_d;
	logic               err_q, err_d;
	logic [LEVEL_W-1:0] drive_q, drive_d;
	logic [LEVEL_W-1:0] prev_q, prev_d;
	logic [LEVEL_W-1:0] start_q, start_d;
	logic [LEVEL_W-1:0] siphon_q, siphon_d;

	fdc_seq_t           seq_q, seq_d;
	logic               in_acc;
	logic               out_free;
	logic               out_load;
	logic               div_start;
	fdc_div_stat_t      div_stat;
	logic [DIVD_W-1:0]  quotient;

	logic [DIVD_W-1:0]  lvl_x100;
	logic [DIVD_W-1:0]  thr_x100;
	logic               below_min;
	logic [LEVEL_W:0]   siphon_lim;
	logic [LEVEL_W:0]   drain_lim;

	logic [LEVEL_W-1:0] diff;
	logic [DIVD_W-1:0]  dividend;
	logic [LEVEL_W-1:0] divisor;
	logic               span_pos;
	logic [LEVEL_W-1:0] estimate;

	fdc_out_t           out_q;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_thr_q  <= 8'd70;
			boost_thr_q <= 8'd120;
			min_pct_q   <= 7'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PUMP_THROTTLE:  pump_thr_q  <= cfg_data;
				CFG_BOOST_THROTTLE: boost_thr_q <= cfg_data;
				CFG_MIN_START_PCT:  min_pct_q   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// level < pct*255/100  <=>  100*level + 100 <= 255*pct
	assign lvl_x100  = DIVD_W'(in_data.level) * DIVD_W'(100) + DIVD_W'(100);
	assign thr_x100  = {1'b0, min_pct_q, 8'b0} - DIVD_W'(min_pct_q);
	assign below_min = lvl_x100 <= thr_x100;

	assign siphon_lim = {1'b0, siphon_q} + {1'b0, SIPHON_RISE};
	assign drain_lim  = {1'b0, in_data.level} + {1'b0, DRAIN_MARGIN};

	assign in_acc = in_valid && !in_stall;

	always_comb begin
		phase_d  = phase_q;
		err_d    = err_q;
		drive_d  = drive_q;
		prev_d   = prev_q;
		start_d  = start_q;
		siphon_d = siphon_q;
		if (in_acc) begin
			if (in_data.func == FUNC_START) begin
				if (phase_q == PH_IDLE) begin
					prev_d = in_data.level;
					if (below_min) begin
						phase_d = PH_FAIL;
						err_d   = 1'b1;
					end else begin
						phase_d = PH_FLOOD;
						start_d = in_data.level;
						drive_d = pump_thr_q;
					end
				end
			end else if (phase_q == PH_FLOOD || phase_q == PH_FINAL ||
					phase_q == PH_DRAIN) begin
				prev_d = in_data.level;
				case (phase_q)
					PH_FLOOD: begin
						if (in_data.level < FINAL_MAX_LEVEL && in_data.level >= prev_q) begin
							siphon_d = prev_q;
							phase_d  = PH_FINAL;
							drive_d  = boost_thr_q;
						end
					end
					PH_FINAL: begin
						if ({1'b0, in_data.level} > siphon_lim) begin
							phase_d = PH_DRAIN;
							drive_d = '0;
						end
					end
					PH_DRAIN: begin
						if (drain_lim > {1'b0, start_q})
							phase_d = PH_IDLE;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			err_q    <= 1'b0;
			drive_q  <= '0;
			prev_q   <= '0;
			start_q  <= '0;
			siphon_q <= '0;
		end else begin
			phase_q  <= phase_d;
			err_q    <= err_d;
			drive_q  <= drive_d;
			prev_q   <= prev_d;
			start_q  <= start_d;
			siphon_q <= siphon_d;
		end
	end

	// estimate operands from the updated state
	assign span_pos = start_q > siphon_q;
	assign diff     = (prev_q > siphon_q) ? prev_q - siphon_q : '0;
	assign dividend = {diff, 8'b0} - DIVD_W'(diff);
	assign divisor  = span_pos ? start_q - siphon_q : LEVEL_W'(1);

	fdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_comb begin
		if (start_q == '0)
			estimate = '0;
		else if (siphon_q == '0)
			estimate = FULL_SCALE - prev_q;
		else if (!span_pos)
			estimate = '0;
		else if (quotient >= DIVD_W'(FULL_SCALE))
			estimate = '0;
		else
			estimate = FULL_SCALE - quotient[LEVEL_W-1:0];
	end

	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_comb begin
		seq_d     = seq_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		in_stall  = 1'b1;
		case (seq_q)
			SEQ_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					seq_d = SEQ_LOAD;
			end
			SEQ_LOAD: begin
				div_start = 1'b1;
				seq_d     = SEQ_DIV;
			end
			SEQ_DIV: begin
				if (div_stat.done) begin
					if (out_free) begin
						out_load = 1'b1;
						seq_d    = SEQ_IDLE;
					end else begin
						seq_d = SEQ_HOLD;
					end
				end
			end
			SEQ_HOLD: begin
				if (out_free) begin
					out_load = 1'b1;
					seq_d    = SEQ_IDLE;
				end
			end
			default: seq_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= SEQ_IDLE;
		else
			seq_q <= seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.phase           <= phase_q;
			out_q.low_water_error <= err_q;
			out_q.pump_drive      <= drive_q;
			out_q.keep_polling    <= phase_q == PH_FLOOD || phase_q == PH_FINAL ||
				phase_q == PH_DRAIN;
			out_q.top_pot_level   <= estimate;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> seq_q == SEQ_DIV)
		else $error("divider finished outside of divide step");

	a_div_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.run |-> in_stall)
		else $error("input taken while divider runs");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAIL |=> phase_q == PH_FAIL)
		else $error("failure phase left before reset");

	a_err_fail: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> phase_q == PH_FAIL)
		else $error("low-water error without failure phase");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q != SEQ_IDLE |=> $stable(phase_q) && $stable(prev_q) && $stable(siphon_q))
		else $error("cycle state changed during estimate");

endmodule

/* sim/fdc_cycle_checker.sv */
// Cycle checker for the flood and drain controller: tracks register writes and input items,
// predicts every status item and compares it with what the core sends. Depends on fdc_pkg.
`timescale 1ns / 1ps

module fdc_cycle_checker import fdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  fdc_in_t            in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  fdc_out_t           out_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [LEVEL_W-1:0] cfg_data,
	output int                 fail_count,
	output int                 pending
);

	// register copies
	logic [LEVEL_W-1:0] pump_thr;
	logic [LEVEL_W-1:0] boost_thr;
	logic [6:0]         start_pct;

	// cycle state
	fdc_phase_t         cyc_phase;
	logic               err_flag;
	logic [LEVEL_W-1:0] drive;
	logic [LEVEL_W-1:0] prev_lvl;
	logic [LEVEL_W-1:0] start_lvl;
	logic [LEVEL_W-1:0] siphon_lvl;

	fdc_out_t status_q[$];
	fdc_out_t want;

	function automatic logic [LEVEL_W-1:0] pot_estimate();
		int diff;
		int quot;
		if (start_lvl == 0)
			return '0;
		if (siphon_lvl == 0)
			return FULL_SCALE - prev_lvl;
		if (start_lvl <= siphon_lvl)
			return '0;
		diff = (prev_lvl > siphon_lvl) ? int'(prev_lvl) - int'(siphon_lvl) : 0;
		quot = diff * int'(FULL_SCALE) / (int'(start_lvl) - int'(siphon_lvl));
		return (quot >= int'(FULL_SCALE)) ? '0 : 8'(int'(FULL_SCALE) - quot);
	endfunction

	function automatic fdc_out_t advance_cycle(input fdc_in_t item);
		fdc_out_t res;
		if (item.func == FUNC_START) begin
			if (cyc_phase == PH_IDLE) begin
				prev_lvl = item.level;
				if (int'(item.level) < int'(start_pct) * 255 / 100) begin
					cyc_phase = PH_FAIL;
					err_flag = 1'b1;
				end else begin
					cyc_phase = PH_FLOOD;
					start_lvl = item.level;
					drive = pump_thr;
				end
			end
		end else if (cyc_phase inside {PH_FLOOD, PH_FINAL, PH_DRAIN}) begin
			case (cyc_phase)
				PH_FLOOD: begin
					// level bottomed out below the mark: siphon has fired
					if (item.level < FINAL_MAX_LEVEL && item.level >= prev_lvl) begin
						siphon_lvl = prev_lvl;
						cyc_phase = PH_FINAL;
						drive = boost_thr;
					end
				end
				PH_FINAL: begin
					if (int'(item.level) > int'(siphon_lvl) + int'(SIPHON_RISE)) begin
						cyc_phase = PH_DRAIN;
						drive = '0;
					end
				end
				default: begin
					if (int'(item.level) + int'(DRAIN_MARGIN) > int'(start_lvl))
						cyc_phase = PH_IDLE;
				end
			endcase
			prev_lvl = item.level;
		end
		res.phase = cyc_phase;
		res.low_water_error = err_flag;
		res.pump_drive = drive;
		res.keep_polling = cyc_phase inside {PH_FLOOD, PH_FINAL, PH_DRAIN};
		res.top_pot_level = pot_estimate();
		return res;
	endfunction

	task automatic note_mismatch(input string what, input fdc_out_t exp_r, input fdc_out_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s: expected phase=%0d lwe=%0b drive=%0d poll=%0b pot=%0d, actual phase=%0d lwe=%0b drive=%0d poll=%0b pot=%0d",
				$realtime, what, exp_r.phase, exp_r.low_water_error, exp_r.pump_drive,
				exp_r.keep_polling, exp_r.top_pot_level, got.phase, got.low_water_error,
				got.pump_drive, got.keep_polling, got.top_pot_level);
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_thr = 8'd70;
			boost_thr = 8'd120;
			start_pct = 7'd50;
			cyc_phase = PH_IDLE;
			err_flag = 1'b0;
			drive = '0;
			prev_lvl = '0;
			start_lvl = '0;
			siphon_lvl = '0;
			status_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PUMP_THROTTLE:  pump_thr = cfg_data;
					CFG_BOOST_THROTTLE: boost_thr = cfg_data;
					CFG_MIN_START_PCT:  start_pct = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				status_q.push_back(advance_cycle(in_data));
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					note_mismatch("unexpected status item", '0, out_data);
				end else begin
					want = status_q.pop_front();
					if (want !== out_data)
						note_mismatch("status mismatch", want, out_data);
				end
			end
		end
		pending = status_q.size();
	end

endmodule

/* sim/tb_top.sv */
// Testbench top for flood_drain_cycle_controller_core: clock, reset, register writes and
// level items, with fdc_cycle_checker doing the checking. Depends on fdc_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
	import fdc_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	fdc_in_t            in_data;
	logic               out_valid;
	logic               out_stall;
	fdc_out_t           out_data;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [LEVEL_W-1:0] cfg_data;
	int                 fail_count;
	int                 pending;

	int         send_idle_pct;
	int         recv_stall_pct;
	logic [6:0] min_pct;
	int         cycle_items;

	flood_drain_cycle_controller_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	fdc_cycle_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
	end

	function automatic int start_floor();
		return int'(min_pct) * 255 / 100;
	endfunction

	task automatic send_item(input fdc_func_t f, input logic [LEVEL_W-1:0] lvl);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{func: f, level: lvl};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// leaves cfg_valid high; caller drops it after the last write
	task automatic write_reg(input fdc_cfg_idx_t idx, input logic [LEVEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [7:0] pump, input logic [7:0] boost, input logic [6:0] pct);
		write_reg(CFG_PUMP_THROTTLE, pump);
		write_reg(CFG_BOOST_THROTTLE, boost);
		write_reg(CFG_MIN_START_PCT, {1'b0, pct});
		cfg_valid <= 1'b0;
		min_pct = pct;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// one cycle item, sometimes preceded by a stray poll or start
	task automatic feed(input fdc_func_t f, input int lvl);
		if ($urandom_range(99, 0) < 8) begin
			if ($urandom_range(1, 0))
				send_item(FUNC_POLL, 8'($urandom));
			else
				send_item(FUNC_START, 8'($urandom_range(255, start_floor())));
		end
		send_item(f, 8'(lvl));
		cycle_items++;
	endtask

	task automatic run_cycle();
		int start_lvl;
		int prev;
		int lvl;
		int siphon;
		int n;
		start_lvl = $urandom_range(255, start_floor());
		feed(FUNC_START, start_lvl);
		prev = start_lvl;
		// flooding: level keeps falling or stays high
		n = $urandom_range(3, 0);
		repeat (n) begin
			if (prev > 0 && $urandom_range(1, 0))
				lvl = $urandom_range(prev - 1, 0);
			else
				lvl = $urandom_range(255, 128);
			feed(FUNC_POLL, lvl);
			prev = lvl;
		end
		if (prev >= 128) begin
			lvl = $urandom_range(127, 0);
			feed(FUNC_POLL, lvl);
			prev = lvl;
		end
		lvl = $urandom_range(127, prev);
		feed(FUNC_POLL, lvl);
		siphon = prev;
		// final flooding until the rise clears the siphon level
		n = $urandom_range(3, 0);
		repeat (n)
			feed(FUNC_POLL, $urandom_range(siphon + 24, 0));
		feed(FUNC_POLL, $urandom_range(255, siphon + 25));
		if ($urandom_range(9, 0) == 0)
			return;
		n = $urandom_range(3, 0);
		if (start_lvl >= 32)
			repeat (n)
				feed(FUNC_POLL, $urandom_range(start_lvl - 32, 0));
		feed(FUNC_POLL, $urandom_range(255, (start_lvl >= 31) ? start_lvl - 31 : 0));
	endtask

	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PUMP_THROTTLE;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		min_pct = 7'd50;
		cycle_items = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers, threshold 127
		send_item(FUNC_POLL, 8'd255);    // poll while idle
		send_item(FUNC_START, 8'd255);
		send_item(FUNC_START, 8'd0);     // start while flooding
		send_item(FUNC_POLL, 8'd200);
		send_item(FUNC_POLL, 8'd100);
		send_item(FUNC_POLL, 8'd100);    // siphon at 100
		send_item(FUNC_POLL, 8'd50);     // below siphon level
		send_item(FUNC_POLL, 8'd125);
		send_item(FUNC_POLL, 8'd223);
		send_item(FUNC_POLL, 8'd224);
		wait_drained();
		set_regs(8'd0, 8'd255, 7'd0);
		send_item(FUNC_START, 8'd0);     // zero start level
		send_item(FUNC_POLL, 8'd0);      // zero siphon level
		send_item(FUNC_POLL, 8'd24);
		send_item(FUNC_POLL, 8'd25);
		send_item(FUNC_POLL, 8'd0);      // low start level, drain ends at once
		send_item(FUNC_START, 8'd10);
		send_item(FUNC_POLL, 8'd20);     // siphon equals start level
		send_item(FUNC_POLL, 8'd255);
		send_item(FUNC_POLL, 8'd255);
		send_item(FUNC_START, 8'd127);
		send_item(FUNC_POLL, 8'd5);
		send_item(FUNC_POLL, 8'd5);
		send_item(FUNC_POLL, 8'd200);    // estimate saturates
		send_item(FUNC_POLL, 8'd90);
		send_item(FUNC_POLL, 8'd96);

		for (int ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph)
				0: set_regs(8'd255, 8'd0, 7'd100);
				4: set_regs(8'd70, 8'd120, 7'd50);
				6: set_regs(8'($urandom), 8'($urandom), 7'($urandom_range(12, 0)));
				default: set_regs(8'($urandom), 8'($urandom), 7'($urandom_range(100, 0)));
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 10; recv_stall_pct = 10; end
			endcase
			cycle_items = 0;
			while (cycle_items < 50)
				run_cycle();
		end

		// threshold above full scale: start refused, failure holds
		wait_drained();
		write_reg(CFG_MIN_START_PCT, 8'd127);
		cfg_valid <= 1'b0;
		min_pct = 7'd127;
		send_item(FUNC_START, 8'd255);
		send_item(FUNC_POLL, 8'd0);
		send_item(FUNC_START, 8'd255);
		wait_drained();
		repeat (40) @(negedge clk);

		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

/* files.f */
hdl/fdc_pkg.sv
hdl/fdc_div.sv
hdl/flood_drain_cycle_controller_core.sv
sim/fdc_cycle_checker.sv
sim/tb_top.sv
